// ===== hw/rtl/mnt_pkg.sv =====
// ----------------------------------------------------------------------------
// Median note tracker package
// Shared constants, the control state type and the cell control struct.
// ----------------------------------------------------------------------------
package mnt_pkg;

  // Number of recent notes kept in the window.
  localparam int WINDOW = 6;
  // Sorted position of the lower median.
  localparam int MED_IDX = (WINDOW - 1) / 2;

  localparam int NOTE_W  = 7;
  localparam int LEVEL_W = 8;
  localparam int COUNT_W = 4;

  // The sort phase feeds the window into the sorter, then lets the sorter settle.
  localparam int SORT_CYCLES = 2 * WINDOW;
  localparam int CNT_W       = $clog2(SORT_CYCLES);

  localparam logic [COUNT_W-1:0] COUNT_MAX   = 4'd15;
  localparam logic [NOTE_W-1:0]  FLOOR_RESET = 7'd45;
  localparam logic [NOTE_W-1:0]  VEL_TOP     = 7'd127;

  // Event kinds.
  localparam logic EV_OFF = 1'b0;
  localparam logic EV_ON  = 1'b1;

  // Control states, one-hot.
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SORT  = 4'b0010,
    S_EMIT1 = 4'b0100,
    S_EMIT2 = 4'b1000
  } state_t;

  // Control that every cell of the row receives.
  typedef struct packed {
    logic shift;     // window moves one place toward cell 0
    logic sort_clr;  // empty the sorting registers
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/median_note_tracker_unit.sv =====
// An item that causes no median loads its event, if any, into the output register as it
// is taken. An item that triggers a median runs through the sorting row (S_SORT) and then
// sends its note-off (S_EMIT1) and, for a note-off and note-on pair, its note-on (S_EMIT2).
// Throughput: one item per cycle without a median while the output does not stall; an item
// that triggers a median holds off new items until its events are sent.
// Reset (rst, synchronous) clears the window, counter, current note and floor to 45.
// ----------------------------------------------------------------------------
// Median note tracker unit
// Turns frame-rate note candidates into note-on and note-off events using a
// hold counter and the lower median of a window of recent notes.
// ----------------------------------------------------------------------------
module median_note_tracker_unit (
  input  logic                               clk,
  input  logic                               rst,
  // Configuration.
  input  logic                               cfg_we,
  input  logic [mnt_pkg::NOTE_W-1:0]         cfg_data,
  // Input items.
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               onset,
  input  logic                               silent,
  input  logic signed [mnt_pkg::LEVEL_W-1:0] level_db,
  input  logic [mnt_pkg::NOTE_W-1:0]         note_in,
  // Result items.
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               event_kind,
  output logic [mnt_pkg::NOTE_W-1:0]         pitch,
  output logic [mnt_pkg::NOTE_W-1:0]         velocity,
  output logic                               last
);

  localparam int W  = mnt_pkg::WINDOW;
  localparam int NW = mnt_pkg::NOTE_W;
  localparam int LEVEL_W_EXT = mnt_pkg::LEVEL_W + 1;

  mnt_pkg::state_t             state;
  mnt_pkg::state_t             state_next;
  logic [NW-1:0]               note_floor;
  logic [mnt_pkg::COUNT_W-1:0] hold_count;
  logic [mnt_pkg::COUNT_W-1:0] hold_count_next;
  logic [NW-1:0]               current_note;
  logic [NW-1:0]               old_note;
  logic [NW-1:0]               vel;
  logic                        on_pending;
  logic [mnt_pkg::CNT_W-1:0]   sort_cnt;

  logic                        accept;
  logic                        out_free;
  logic                        fire;
  logic                        feed;
  logic                        sort_done;
  logic signed [LEVEL_W_EXT-1:0] vel_sum;
  logic [NW-1:0]               vel_sat;
  logic [NW-1:0]               median;
  logic [NW-1:0]               tail_in;
  mnt_pkg::cell_ctrl_t         ctrl;

  logic [NW-1:0] win      [W];
  logic [NW-1:0] sort_val [W];
  logic [NW-1:0] sort_d   [W+1];
  logic          sort_v   [W+1];

  // Handshake.
  assign out_free = !out_valid || !out_stall;
  assign in_stall = !((state == mnt_pkg::S_IDLE) && out_free);
  assign accept   = in_valid && !in_stall;

  // Hold counter update and the firing condition.
  always_comb begin
    hold_count_next = hold_count;
    if (onset) begin
      hold_count_next = silent ? '0 : mnt_pkg::COUNT_W'(1);
    end else if (hold_count != '0 && hold_count != mnt_pkg::COUNT_MAX) begin
      hold_count_next = hold_count + 1'b1;
    end
  end
  assign fire = !onset && (hold_count_next == mnt_pkg::COUNT_W'(W));

  // Velocity: 127 plus the level, saturated to 0..127.
  assign vel_sum = LEVEL_W_EXT'(level_db) + LEVEL_W_EXT'(signed'({2'b00, mnt_pkg::VEL_TOP}));
  always_comb begin
    if (vel_sum < 0) begin
      vel_sat = '0;
    end else if (vel_sum > LEVEL_W_EXT'(signed'({2'b00, mnt_pkg::VEL_TOP}))) begin
      vel_sat = mnt_pkg::VEL_TOP;
    end else begin
      vel_sat = vel_sum[NW-1:0];
    end
  end

  // Sort phase: rotate the window into the sorter, then let it settle.
  assign feed      = (state == mnt_pkg::S_SORT) && (sort_cnt < mnt_pkg::CNT_W'(W));
  assign sort_done = (state == mnt_pkg::S_SORT)
                     && (sort_cnt == mnt_pkg::CNT_W'(mnt_pkg::SORT_CYCLES - 1));
  assign median    = sort_val[mnt_pkg::MED_IDX];

  assign ctrl.shift    = accept || feed;
  assign ctrl.sort_clr = accept;
  assign tail_in       = feed ? win[0] : note_in;
  assign sort_d[0]     = win[0];
  assign sort_v[0]     = feed;

  // Row of cells: window shifts toward cell 0, sorter values move away from it.
  for (genvar k = 0; k < W; k++) begin : g_cell
    mnt_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .win_in     ((k == W - 1) ? tail_in : win[(k + 1) % W]),
      .win        (win[k]),
      .sort_in_v  (sort_v[k]),
      .sort_in    (sort_d[k]),
      .sort_out_v (sort_v[k+1]),
      .sort_out   (sort_d[k+1]),
      .sort_val   (sort_val[k])
    );
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      mnt_pkg::S_IDLE: begin
        if (accept && fire) begin
          state_next = mnt_pkg::S_SORT;
        end
      end
      mnt_pkg::S_SORT: begin
        if (sort_done) begin
          state_next = mnt_pkg::S_EMIT1;
        end
      end
      mnt_pkg::S_EMIT1: begin
        if (out_free) begin
          state_next = on_pending ? mnt_pkg::S_EMIT2 : mnt_pkg::S_IDLE;
        end
      end
      mnt_pkg::S_EMIT2: begin
        if (out_free) begin
          state_next = mnt_pkg::S_IDLE;
        end
      end
      default: state_next = mnt_pkg::S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= mnt_pkg::S_IDLE;
      note_floor   <= mnt_pkg::FLOOR_RESET;
      hold_count   <= '0;
      current_note <= '0;
      sort_cnt     <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        note_floor <= cfg_data;
      end
      if (accept) begin
        hold_count <= hold_count_next;
        sort_cnt   <= '0;
      end else if (state == mnt_pkg::S_SORT) begin
        sort_cnt <= sort_cnt + 1'b1;
      end
      if (sort_done) begin
        current_note <= median;
      end
    end
  end

  // Per-item payload kept for the events.
  always_ff @(posedge clk) begin
    if (accept) begin
      vel      <= vel_sat;
      old_note <= current_note;
    end
    if (sort_done) begin
      on_pending <= median > note_floor;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && onset && silent) begin
      out_valid <= 1'b1;
    end else if ((state == mnt_pkg::S_EMIT1 || state == mnt_pkg::S_EMIT2) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && onset && silent) begin
      event_kind <= mnt_pkg::EV_OFF;
      pitch      <= current_note;
      velocity   <= '0;
      last       <= 1'b1;
    end else if (state == mnt_pkg::S_EMIT1 && out_free) begin
      event_kind <= mnt_pkg::EV_OFF;
      pitch      <= old_note;
      velocity   <= '0;
      last       <= !on_pending;
    end else if (state == mnt_pkg::S_EMIT2 && out_free) begin
      event_kind <= mnt_pkg::EV_ON;
      pitch      <= current_note;
      velocity   <= vel;
      last       <= 1'b1;
    end
  end

  // A note-on is always the final event of its item.
  a_on_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && event_kind == mnt_pkg::EV_ON) |-> last)
    else $error("note-on event without last flag");

  // A note-on is only sent for notes above the floor.
  a_on_floor: assert property (@(posedge clk) disable iff (rst)
    (out_valid && event_kind == mnt_pkg::EV_ON) |-> (pitch > note_floor))
    else $error("note-on at or below the floor");

  // A note-off carries zero velocity.
  a_off_vel: assert property (@(posedge clk) disable iff (rst)
    (out_valid && event_kind == mnt_pkg::EV_OFF) |-> (velocity == '0))
    else $error("note-off with nonzero velocity");

  // No item is taken while the sorter is busy.
  a_sort_stall: assert property (@(posedge clk) disable iff (rst)
    (state == mnt_pkg::S_SORT) |-> in_stall)
    else $error("input accepted during sort");

endmodule

// ===== hw/rtl/mnt_cell.sv =====
// ----------------------------------------------------------------------------
// Median note tracker cell
// One window entry plus one stage of a systolic insertion sorter.
// ----------------------------------------------------------------------------
module mnt_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  mnt_pkg::cell_ctrl_t         ctrl,
  input  logic [mnt_pkg::NOTE_W-1:0]  win_in,
  output logic [mnt_pkg::NOTE_W-1:0]  win,
  input  logic                        sort_in_v,
  input  logic [mnt_pkg::NOTE_W-1:0]  sort_in,
  output logic                        sort_out_v,
  output logic [mnt_pkg::NOTE_W-1:0]  sort_out,
  output logic [mnt_pkg::NOTE_W-1:0]  sort_val
);

  logic sort_full;

  // Window entry: takes the neighbor's note on every shift.
  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (ctrl.shift) begin
      win <= win_in;
    end
  end

  // Sorter stage: keeps the smaller value and hands the larger one on.
  always_ff @(posedge clk) begin
    if (rst || ctrl.sort_clr) begin
      sort_full  <= 1'b0;
      sort_out_v <= 1'b0;
    end else if (sort_in_v) begin
      if (!sort_full) begin
        sort_full  <= 1'b1;
        sort_out_v <= 1'b0;
      end else begin
        sort_out_v <= 1'b1;
      end
    end else begin
      sort_out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sort_in_v) begin
      if (!sort_full) begin
        sort_val <= sort_in;
      end else if (sort_in < sort_val) begin
        sort_val <= sort_in;
        sort_out <= sort_val;
      end else begin
        sort_out <= sort_in;
      end
    end
  end

endmodule
